[rtl/core/bat_pkg.sv]
// Shared types and codes for the breakpoint address table.
`default_nettype none

package bat_pkg;

  // Request command codes.
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // Widths of the reported response fields.
  localparam int SLOT_W  = 4;
  localparam int COUNT_W = 5;

  // Response status codes.
  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_PRESENT  = 3'd1,
    ST_FULL     = 3'd2,
    ST_REMOVED  = 3'd3,
    ST_MISSING  = 3'd4
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    start;
    logic    search;
    logic    shift;
    logic    append;
    logic    load;
    status_t res_status;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_remove;
    logic hit;
    logic scan_done;
    logic full;
    logic out_busy;
  } dp_sts_t;

endpackage

`default_nettype wire

[rtl/core/bat_channels.sv]
// Request and response channel interfaces of the breakpoint address table.
`default_nettype none

interface bat_req_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [31:0] address;

  modport source (output valid, output command, output address, input ready);
  modport sink (input valid, input command, input address, output ready);
endinterface

interface bat_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [3:0] slot;
  logic [4:0] entry_count;

  modport source (output valid, output status, output slot, output entry_count, input ready);
  modport sink (input valid, input status, input slot, input entry_count, output ready);
endinterface

`default_nettype wire

[rtl/core/bat_ctrl.sv]
// Sequencing state machine of the breakpoint address table.
`default_nettype none

module bat_ctrl import bat_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT,
    S_APPEND,
    S_FINISH
  } state_t;

  state_t  state, state_next;
  status_t res_status, res_status_next;

  // Next state and the status code to report.
  always_comb begin
    state_next      = state;
    res_status_next = res_status;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (sts.hit) begin
          if (sts.is_remove) begin
            res_status_next = ST_REMOVED;
            state_next      = S_SHIFT;
          end else begin
            res_status_next = ST_PRESENT;
            state_next      = S_FINISH;
          end
        end else if (sts.scan_done) begin
          if (sts.is_remove) begin
            res_status_next = ST_MISSING;
            state_next      = S_FINISH;
          end else if (sts.full) begin
            res_status_next = ST_FULL;
            state_next      = S_FINISH;
          end else begin
            res_status_next = ST_INSERTED;
            state_next      = S_APPEND;
          end
        end
      end
      S_SHIFT: begin
        if (sts.scan_done) begin
          state_next = S_FINISH;
        end
      end
      S_APPEND: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!sts.out_busy) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and the registered status code.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      res_status <= ST_INSERTED;
    end else begin
      state      <= state_next;
      res_status <= res_status_next;
    end
  end

  // Commands follow the current state.
  assign in_ready       = (state == S_IDLE);
  assign cmd.start      = (state == S_IDLE) && in_valid;
  assign cmd.search     = (state == S_SEARCH);
  assign cmd.shift      = (state == S_SHIFT);
  assign cmd.append     = (state == S_APPEND);
  assign cmd.load       = (state == S_FINISH) && !sts.out_busy;
  assign cmd.res_status = res_status;

endmodule

`default_nettype wire

[rtl/core/bat_datapath.sv]
// Address store, scan pointer, fill count and response register of the table.
`default_nettype none

module bat_datapath import bat_pkg::*; #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_command,
  input  logic [31:0]        in_address,
  input  dp_cmd_t            cmd,
  output dp_sts_t            sts,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_status,
  output logic [SLOT_W-1:0]  out_slot,
  output logic [COUNT_W-1:0] out_entry_count
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  logic              req_command;
  logic [31:0]       req_address;
  logic [31:0]       mem [TABLE_DEPTH];
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  scan;
  logic              rd_valid;
  logic [IDX_W-1:0]  rd_idx;
  logic [31:0]       rd_data;
  logic [IDX_W-1:0]  slot_reg;

  logic              scan_live;
  logic              match;
  logic              search_hit;
  logic              scan_done;
  logic              step;
  logic              rd_en;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [31:0]       wr_data;
  logic              zero_slot;
  logic [IDX_W+SLOT_W-1:0]  slot_wide;
  logic [CNT_W+COUNT_W-1:0] count_wide;

  // Compare and progress flags.
  assign scan_live  = (scan < count);
  assign match      = rd_valid && (rd_data == req_address);
  assign search_hit = cmd.search && match;
  assign scan_done  = !scan_live && !rd_valid;
  assign step       = cmd.search || cmd.shift;
  assign rd_en      = step && scan_live;

  assign sts.is_remove = (req_command == CMD_REMOVE);
  assign sts.hit       = match;
  assign sts.scan_done = scan_done;
  assign sts.full      = (count == CNT_W'(TABLE_DEPTH));
  assign sts.out_busy  = out_valid && !out_ready;

  // Write port: append at the fill count, or move an entry down one slot.
  assign wr_en   = cmd.append || (cmd.shift && rd_valid);
  assign wr_addr = cmd.append ? count[IDX_W-1:0] : (rd_idx - IDX_W'(1));
  assign wr_data = cmd.append ? req_address : rd_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port, driven by the scan pointer.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[scan[IDX_W-1:0]];
      rd_idx  <= scan[IDX_W-1:0];
    end
  end

  // Scan pointer and read pipeline flag. A search hit restarts the scan just
  // past the matching slot, which is where a removal starts moving entries.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan     <= '0;
      rd_valid <= 1'b0;
    end else if (cmd.start) begin
      scan     <= '0;
      rd_valid <= 1'b0;
    end else if (search_hit) begin
      scan     <= CNT_W'(rd_idx) + CNT_W'(1);
      rd_valid <= 1'b0;
    end else if (step) begin
      if (scan_live) begin
        scan <= scan + CNT_W'(1);
      end
      rd_valid <= scan_live;
    end
  end

  // Latched request.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_command <= in_command;
      req_address <= in_address;
    end
  end

  // Fill count: grows on append, shrinks when a removal's move finishes.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.append) begin
      count <= count + CNT_W'(1);
    end else if (cmd.shift && scan_done) begin
      count <= count - CNT_W'(1);
    end
  end

  // Slot to report.
  always_ff @(posedge clk) begin
    if (search_hit) begin
      slot_reg <= rd_idx;
    end else if (cmd.append) begin
      slot_reg <= count[IDX_W-1:0];
    end
  end

  // Response register; a full table or a missing address reports slot zero.
  assign zero_slot  = (cmd.res_status == ST_FULL) || (cmd.res_status == ST_MISSING);
  assign slot_wide  = zero_slot ? '0 : {{SLOT_W{1'b0}}, slot_reg};
  assign count_wide = {{COUNT_W{1'b0}}, count};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_status      <= cmd.res_status;
      out_slot        <= slot_wide[SLOT_W-1:0];
      out_entry_count <= count_wide[COUNT_W-1:0];
    end
  end

  // The fill count never passes the table depth.
  assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TABLE_DEPTH))
    else $error("fill count beyond table depth");

  // An append only happens when the table has room.
  assert property (@(posedge clk) disable iff (rst)
    cmd.append |-> (count < CNT_W'(TABLE_DEPTH)))
    else $error("append into a full table");

  // An entry move never targets below slot zero.
  assert property (@(posedge clk) disable iff (rst)
    (cmd.shift && rd_valid) |-> (rd_idx != '0))
    else $error("entry move from slot zero");

  // A loaded response shows up as valid; a load waits until the previous one has left or leaves now.
  assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> out_valid)
    else $error("loaded response not presented");

endmodule

`default_nettype wire

[rtl/core/breakpoint_address_table.sv]
// Top level of the breakpoint address table: controller plus datapath.
//
//   channel  direction  payload                          transfers when
//   req      in         command, address                 req.valid && req.ready
//   rsp      out        status, slot, entry_count        rsp.valid && rsp.ready
//
// One request is handled at a time. The response takes longest to load for an
// insert of a new address and for a removal of any entry but the last. The scan
// over the single-read-port address store sets this: one entry per cycle through
// a registered read, and a last step to see the scan end. A removal then moves
// the later entries down one slot. The controller then goes back to idle before
// it takes the next request.
// A finished response waits while the previous one still sits in the output
// register, and a new request is taken while the latest response waits there.
// Reset (synchronous, active high) empties the table; no clearing pass is run.
`default_nettype none

module breakpoint_address_table import bat_pkg::*; #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst,
  bat_req_if.sink   req,
  bat_rsp_if.source rsp
);

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    in_ready;

  // Sequencer.
  bat_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Storage, scan and response register.
  bat_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .in_command      (req.command),
    .in_address      (req.address),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (rsp.valid),
    .out_ready       (rsp.ready),
    .out_status      (rsp.status),
    .out_slot        (rsp.slot),
    .out_entry_count (rsp.entry_count)
  );

  assign req.ready = in_ready;

  // A request is taken only when the controller is idle, and then a search starts.
  assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("second request taken while busy");

  // A response never reports more entries than the table holds.
  assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (TABLE_DEPTH < 32)) |-> (32'(rsp.entry_count) <= 32'(TABLE_DEPTH)))
    else $error("reported count beyond table depth");

  // A full-table or not-found response always reports slot zero.
  assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && ((rsp.status == ST_FULL) || (rsp.status == ST_MISSING)))
      |-> (rsp.slot == '0))
    else $error("nonzero slot on a miss");

endmodule

`default_nettype wire
